// ===== rtl/modular_exponentiation_top_macros.svh =====
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define MEXP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular_exponentiation: same-cycle check failed");
// Next-cycle implication.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_exponentiation: next-cycle check failed");
`else
`define MEXP_ASSERT_NOW(label, ante, cons)
`define MEXP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/mexp_pkg.sv =====
// Shared constants and controller/datapath interface types.
package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    // which modular multiply is in flight
    localparam logic [1:0] OP_REDUCE = 2'd0;  // base mod m, as 1 * base
    localparam logic [1:0] OP_SQUARE = 2'd1;  // r * r
    localparam logic [1:0] OP_MULT   = 2'd2;  // r * base

    typedef struct packed {
        logic       load_in;      // capture base/exponent, r <= 1
        logic       mul_start;    // clear accumulator, load operands for op
        logic       dbl;          // acc <= 2*acc mod m
        logic       add;          // acc <= acc + (bit ? a : 0) mod m, shift multiplier
        logic       wb;           // write accumulator back for op
        logic       exp_shift;    // move to next exponent bit
        logic       load_result;  // capture r into output register
        logic [1:0] op;
    } mexp_cmd_t;

    typedef struct packed {
        logic exp_msb;    // current exponent bit
    } mexp_sts_t;

endpackage

// ===== rtl/mexp_dp.sv =====
// Datapath: modulus register, operands and bit-serial modular multiply accumulator.
module mexp_dp
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [WIDTH-1:0] cfg_wr_data,
    input  logic [WIDTH-1:0] base,
    input  logic [WIDTH-1:0] exponent,
    input  mexp_cmd_t        cmd,
    output mexp_sts_t        sts,
    output logic [WIDTH-1:0] power_mod
);

    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] bsh_reg;
    logic [WIDTH-1:0] result_reg;

    logic [WIDTH-1:0] addend;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] sum_red;

    // one add-and-reduce per cycle; both operands are below m
    always_comb
    begin
        if (cmd.dbl)
            addend = acc_reg;
        else if (bsh_reg[WIDTH-1])
            addend = a_reg;
        else
            addend = '0;
        sum = {1'b0, acc_reg} + {1'b0, addend};
        if (sum >= {1'b0, mod_reg})
            sum_red = WIDTH'(sum - {1'b0, mod_reg});
        else
            sum_red = sum[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WIDTH'(2);
        end
        else if (cfg_wr_en)
        begin
            mod_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            base_reg <= base;
            exp_reg  <= exponent;
            r_reg    <= WIDTH'(1);
        end
        if (cmd.mul_start)
        begin
            acc_reg <= '0;
            case (cmd.op)
                OP_REDUCE:
                begin
                    a_reg   <= WIDTH'(1);
                    bsh_reg <= base_reg;
                end
                OP_SQUARE:
                begin
                    a_reg   <= r_reg;
                    bsh_reg <= r_reg;
                end
                default:
                begin
                    a_reg   <= r_reg;
                    bsh_reg <= base_reg;
                end
            endcase
        end
        if (cmd.dbl)
            acc_reg <= sum_red;
        if (cmd.add)
        begin
            acc_reg <= sum_red;
            bsh_reg <= {bsh_reg[WIDTH-2:0], 1'b0};
        end
        if (cmd.wb)
        begin
            if (cmd.op == OP_REDUCE)
                base_reg <= acc_reg;
            else
                r_reg <= acc_reg;
        end
        if (cmd.exp_shift)
            exp_reg <= {exp_reg[WIDTH-2:0], 1'b0};
        if (cmd.load_result)
            result_reg <= (mod_reg < WIDTH'(2)) ? '0 : r_reg;
    end

    assign sts.exp_msb   = exp_reg[WIDTH-1];
    assign power_mod     = result_reg;

endmodule

// ===== rtl/mexp_ctrl.sv =====
// Controller: sequences reduction, square-and-multiply and the output handshake.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  mexp_sts_t sts,
    output mexp_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DBL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0] exp_cnt_reg, exp_cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        bit_cnt_next = bit_cnt_reg;
        exp_cnt_next = exp_cnt_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_REDUCE;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                cmd.mul_start = 1'b1;
                bit_cnt_next  = CNT_W'(WIDTH - 1);
                state_next    = S_DBL;
            end
            S_DBL:
            begin
                cmd.dbl    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                if (bit_cnt_reg == '0)
                    state_next = S_WB;
                else
                begin
                    bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                    state_next   = S_DBL;
                end
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (op_reg == OP_REDUCE)
                begin
                    op_next      = OP_SQUARE;
                    exp_cnt_next = CNT_W'(WIDTH - 1);
                    state_next   = S_START;
                end
                else if (op_reg == OP_SQUARE && sts.exp_msb)
                begin
                    op_next    = OP_MULT;
                    state_next = S_START;
                end
                else if (exp_cnt_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    exp_cnt_next  = exp_cnt_reg - CNT_W'(1);
                    cmd.exp_shift = 1'b1;
                    op_next       = OP_SQUARE;
                    state_next    = S_START;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_REDUCE;
            bit_cnt_reg   <= '0;
            exp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            bit_cnt_reg   <= bit_cnt_next;
            exp_cnt_reg   <= exp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
// Top level of the modular exponentiation block: power_mod = base^exponent mod modulus.
//
// Input channel (in_valid/in_ready, base, exponent): one transaction per computation.
// Output channel (out_valid/out_ready, power_mod): exactly one transaction per input.
// Configuration: cfg_wr_en/cfg_wr_data write the modulus; write only
// while the block is idle. Reset value of the modulus is 2.
// Each modular multiply is bit serial: one add-and-reduce per cycle, two per
// multiplier bit, between a start step and a write-back step. An item runs one
// reduction of the base, WIDTH squarings and one multiply per set exponent bit,
// all on one shared add/compare unit; one item is in work at a time.
// in_ready is high only while the controller is idle. A finished result sits in
// the output register; the next input is accepted while it waits, and if the
// receiver still stalls when the next result is done, the controller holds it
// until the output register frees. A modulus below two gives 0 for every item.
// Reset (rst_n, asynchronous, active low) clears control state and drops
// out_valid; any transaction in flight is discarded.
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [WIDTH-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] base,
    input  logic [WIDTH-1:0] exponent,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] power_mod
);

    mexp_cmd_t cmd;
    mexp_sts_t sts;

    // sequencer: state, bit and exponent counters, output valid
    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // operands, accumulator, modulus and result registers
    mexp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .base        (base),
        .exponent    (exponent),
        .cmd         (cmd),
        .sts         (sts),
        .power_mod   (power_mod)
    );

    // an accepted transaction makes the block busy
    `MEXP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // a result never overwrites one the receiver has not taken
    `MEXP_ASSERT_NOW(a_no_overwrite, cmd.load_result, !out_valid || out_ready)
    // a captured result is offered in the next cycle
    `MEXP_ASSERT_NEXT(a_result_offered, cmd.load_result, out_valid)

endmodule
